@@ design/sic_pkg.sv @@
// Shared types and widths for the segment intersection classifier.
// No dependencies; used by every module in the design folder except sic_check.
package sic_pkg;

    localparam int FieldBits = 32;
    localparam int CoordBits = 32;
    localparam int DiffBits  = CoordBits + 1;
    localparam int ProdBits  = 2 * DiffBits;

    typedef logic signed [CoordBits-1:0] coord_t;
    typedef logic signed [DiffBits-1:0]  diff_t;
    typedef logic signed [ProdBits-1:0]  prod_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } point_t;

    // Orientation as the two cross product terms; sign of lhs - rhs
    typedef struct packed {
        prod_t lhs;
        prod_t rhs;
    } orient_t;

    typedef enum logic [1:0] {
        REL_NONE    = 2'd0,
        REL_TOUCH   = 2'd1,
        REL_PROPER  = 2'd2,
        REL_OVERLAP = 2'd3
    } relation_t;

endpackage

@@ design/sic_orient.sv @@
// Cross product terms for the orientation of point c against line a->b.
// Depends on sic_pkg.
module sic_orient (
    input  sic_pkg::point_t  a,
    input  sic_pkg::point_t  b,
    input  sic_pkg::point_t  c,
    output sic_pkg::orient_t o
);

    sic_pkg::diff_t ux;
    sic_pkg::diff_t uy;
    sic_pkg::diff_t vx;
    sic_pkg::diff_t vy;
    sic_pkg::prod_t lhs;
    sic_pkg::prod_t rhs;

    assign ux = sic_pkg::diff_t'(b.x) - sic_pkg::diff_t'(a.x);
    assign uy = sic_pkg::diff_t'(b.y) - sic_pkg::diff_t'(a.y);
    assign vx = sic_pkg::diff_t'(c.x) - sic_pkg::diff_t'(a.x);
    assign vy = sic_pkg::diff_t'(c.y) - sic_pkg::diff_t'(a.y);

    assign lhs = ux * vy;
    assign rhs = uy * vx;

    assign o.lhs = lhs;
    assign o.rhs = rhs;

endmodule

@@ design/sic_classify.sv @@
// Relation decode from four orientation term pairs and the endpoint coordinates.
// Depends on sic_pkg.
module sic_classify (
    input  sic_pkg::point_t    a,
    input  sic_pkg::point_t    b,
    input  sic_pkg::point_t    c,
    input  sic_pkg::point_t    d,
    input  sic_pkg::orient_t   oc,
    input  sic_pkg::orient_t   od,
    input  sic_pkg::orient_t   oa,
    input  sic_pkg::orient_t   ob,
    output sic_pkg::relation_t relation
);

    function automatic logic is_zero(input sic_pkg::orient_t o);
        sic_pkg::prod_t l;
        sic_pkg::prod_t r;
        l = o.lhs;
        r = o.rhs;
        return l == r;
    endfunction

    function automatic logic is_neg(input sic_pkg::orient_t o);
        sic_pkg::prod_t l;
        sic_pkg::prod_t r;
        l = o.lhs;
        r = o.rhs;
        return l < r;
    endfunction

    function automatic logic between(input sic_pkg::coord_t e0, input sic_pkg::coord_t e1,
                                     input sic_pkg::coord_t p);
        return ((p >= e0) && (p <= e1)) || ((p >= e1) && (p <= e0));
    endfunction

    function automatic logic in_box(input sic_pkg::point_t e0, input sic_pkg::point_t e1,
                                    input sic_pkg::point_t p);
        return between(e0.x, e1.x, p.x) && between(e0.y, e1.y, p.y);
    endfunction

    function automatic sic_pkg::coord_t cmin(input sic_pkg::coord_t u, input sic_pkg::coord_t v);
        return (u < v) ? u : v;
    endfunction

    function automatic sic_pkg::coord_t cmax(input sic_pkg::coord_t u, input sic_pkg::coord_t v);
        return (u > v) ? u : v;
    endfunction

    function automatic logic span_overlap(input sic_pkg::coord_t p0, input sic_pkg::coord_t p1,
                                          input sic_pkg::coord_t q0, input sic_pkg::coord_t q1);
        return cmax(cmin(p0, p1), cmin(q0, q1)) < cmin(cmax(p0, p1), cmax(q0, q1));
    endfunction

    logic zc, zd, za, zb;
    logic nc, nd, na, nb;
    logic collinear;
    logic overlap;
    logic touch;
    logic proper;

    assign zc = is_zero(oc);
    assign zd = is_zero(od);
    assign za = is_zero(oa);
    assign zb = is_zero(ob);
    assign nc = is_neg(oc);
    assign nd = is_neg(od);
    assign na = is_neg(oa);
    assign nb = is_neg(ob);

    assign collinear = zc && zd && za && zb;
    assign overlap   = span_overlap(a.x, b.x, c.x, d.x) || span_overlap(a.y, b.y, c.y, d.y);
    assign touch     = (zc && in_box(a, b, c)) || (zd && in_box(a, b, d))
                    || (za && in_box(c, d, a)) || (zb && in_box(c, d, b));
    assign proper    = !zc && !zd && (nc != nd) && !za && !zb && (na != nb);

    always_comb
    begin
        if (collinear && overlap)
        begin
            relation = sic_pkg::REL_OVERLAP;
        end
        else if (!collinear && proper)
        begin
            relation = sic_pkg::REL_PROPER;
        end
        else if (touch)
        begin
            relation = sic_pkg::REL_TOUCH;
        end
        else
        begin
            relation = sic_pkg::REL_NONE;
        end
    end

endmodule

@@ design/segment_intersection_classifier.sv @@
// Segment pair intersection classifier: relation of segments AB and CD.
// Pipeline: input registers, orientation term registers, then the relation register.
// Throughput: one pair per cycle when not stalled; the cross product stage sets the cycle time.
// Reset: rst_n clears all stage valid flags; payload registers are not reset.
// Depends on sic_pkg, sic_orient and sic_classify.
module segment_intersection_classifier (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          pair_valid,
    output logic                          pair_stall,
    input  logic signed [sic_pkg::FieldBits-1:0] ax,
    input  logic signed [sic_pkg::FieldBits-1:0] ay,
    input  logic signed [sic_pkg::FieldBits-1:0] bx,
    input  logic signed [sic_pkg::FieldBits-1:0] by,
    input  logic signed [sic_pkg::FieldBits-1:0] cx,
    input  logic signed [sic_pkg::FieldBits-1:0] cy,
    input  logic signed [sic_pkg::FieldBits-1:0] dx,
    input  logic signed [sic_pkg::FieldBits-1:0] dy,
    output logic                          relation_valid,
    input  logic                          relation_stall,
    output logic [1:0]                    relation
);

    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic out_valid_reg, out_valid_next;
    logic out_free;
    logic s2_ready;
    logic s1_ready;

    sic_pkg::point_t s1_a_reg, s1_b_reg, s1_c_reg, s1_d_reg;
    sic_pkg::point_t s2_a_reg, s2_b_reg, s2_c_reg, s2_d_reg;
    sic_pkg::orient_t oc_next, od_next, oa_next, ob_next;
    sic_pkg::orient_t oc_reg, od_reg, oa_reg, ob_reg;
    sic_pkg::relation_t rel_next;
    sic_pkg::relation_t rel_reg;

    assign out_free = !out_valid_reg || !relation_stall;
    assign s2_ready = !s2_valid_reg || out_free;
    assign s1_ready = !s1_valid_reg || s2_ready;

    assign s1_valid_next  = s1_ready ? pair_valid : s1_valid_reg;
    assign s2_valid_next  = s2_ready ? s1_valid_reg : s2_valid_reg;
    assign out_valid_next = out_free ? s2_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the low coordinate bits of each field
    always_ff @(posedge clk)
    begin
        if (pair_valid && s1_ready)
        begin
            s1_a_reg <= '{x: ax[sic_pkg::CoordBits-1:0], y: ay[sic_pkg::CoordBits-1:0]};
            s1_b_reg <= '{x: bx[sic_pkg::CoordBits-1:0], y: by[sic_pkg::CoordBits-1:0]};
            s1_c_reg <= '{x: cx[sic_pkg::CoordBits-1:0], y: cy[sic_pkg::CoordBits-1:0]};
            s1_d_reg <= '{x: dx[sic_pkg::CoordBits-1:0], y: dy[sic_pkg::CoordBits-1:0]};
        end
    end

    sic_orient u_orient_c (.a(s1_a_reg), .b(s1_b_reg), .c(s1_c_reg), .o(oc_next));
    sic_orient u_orient_d (.a(s1_a_reg), .b(s1_b_reg), .c(s1_d_reg), .o(od_next));
    sic_orient u_orient_a (.a(s1_c_reg), .b(s1_d_reg), .c(s1_a_reg), .o(oa_next));
    sic_orient u_orient_b (.a(s1_c_reg), .b(s1_d_reg), .c(s1_b_reg), .o(ob_next));

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s2_ready)
        begin
            s2_a_reg <= s1_a_reg;
            s2_b_reg <= s1_b_reg;
            s2_c_reg <= s1_c_reg;
            s2_d_reg <= s1_d_reg;
            oc_reg   <= oc_next;
            od_reg   <= od_next;
            oa_reg   <= oa_next;
            ob_reg   <= ob_next;
        end
    end

    sic_classify u_classify (
        .a        (s2_a_reg),
        .b        (s2_b_reg),
        .c        (s2_c_reg),
        .d        (s2_d_reg),
        .oc       (oc_reg),
        .od       (od_reg),
        .oa       (oa_reg),
        .ob       (ob_reg),
        .relation (rel_next)
    );

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && out_free)
        begin
            rel_reg <= rel_next;
        end
    end

    assign pair_stall     = !s1_ready;
    assign relation_valid = out_valid_reg;
    assign relation       = rel_reg;

endmodule

@@ design/sic_check.sv @@
// Port-level checker for the segment intersection classifier, with its bind.
// Depends on the top level's ports only.
module sic_check (
    input logic       clk,
    input logic       rst_n,
    input logic       pair_valid,
    input logic       pair_stall,
    input logic       relation_valid,
    input logic       relation_stall,
    input logic [1:0] relation
);

    // Empty result register means the whole pipe can advance
    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !relation_valid |-> !pair_stall)
        else $error("pair stalled while no relation word is pending");

    // Accepted pair word must reach the output while relation_stall stays low
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (pair_valid && !pair_stall) ##1 !relation_stall ##1 !relation_stall |=> relation_valid)
        else $error("relation word missing after unstalled pipe");

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (relation_valid && relation_stall) |=> relation_valid)
        else $error("relation word dropped while stalled");

    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (relation_valid && relation_stall) |=> $stable(relation))
        else $error("relation word changed while stalled");

endmodule

bind segment_intersection_classifier sic_check u_sic_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .pair_valid     (pair_valid),
    .pair_stall     (pair_stall),
    .relation_valid (relation_valid),
    .relation_stall (relation_stall),
    .relation       (relation)
);

@@ tb/sv/segment_intersection_classifier_tb.sv @@
// Self-checking testbench for segment_intersection_classifier: directed and random segment pairs
// with random idling on both channels; a scoreboard class predicts every relation word.
// Depends on sic_pkg and the segment_intersection_classifier RTL.
module segment_intersection_classifier_tb;

    localparam int WideBits   = 2 * sic_pkg::CoordBits + 4;
    localparam int CycleLimit = 200000;
    localparam int RandomPerPhase = 375;

    typedef logic signed [sic_pkg::FieldBits-1:0] field_t;
    typedef logic signed [WideBits-1:0] wide_t;
    typedef field_t pair_t [8];

    typedef struct {
        wide_t x;
        wide_t y;
    } wpoint_t;

    localparam field_t CoordMax = {1'b0, {(sic_pkg::FieldBits-1){1'b1}}};
    localparam field_t CoordMin = {1'b1, {(sic_pkg::FieldBits-1){1'b0}}};

    class relation_scoreboard;
        sic_pkg::relation_t expected_q[$];
        int mismatches;

        function new();
            mismatches = 0;
        endfunction

        function wide_t widen(field_t f);
            logic signed [sic_pkg::CoordBits-1:0] c;
            c = f[sic_pkg::CoordBits-1:0];
            return c;
        endfunction

        function int orient_sign(wpoint_t a, wpoint_t b, wpoint_t c);
            wide_t cross_val;
            cross_val = (b.x - a.x) * (c.y - a.y) - (b.y - a.y) * (c.x - a.x);
            if (cross_val < 0)
                return -1;
            return (cross_val == 0) ? 0 : 1;
        endfunction

        function wide_t wmin(wide_t a, wide_t b);
            return (a < b) ? a : b;
        endfunction

        function wide_t wmax(wide_t a, wide_t b);
            return (a > b) ? a : b;
        endfunction

        function bit on_segment(wpoint_t a, wpoint_t b, wpoint_t p);
            return orient_sign(a, b, p) == 0
                && p.x >= wmin(a.x, b.x) && p.x <= wmax(a.x, b.x)
                && p.y >= wmin(a.y, b.y) && p.y <= wmax(a.y, b.y);
        endfunction

        function bit spans_overlap(wide_t a, wide_t b, wide_t c, wide_t d);
            return wmax(wmin(a, b), wmin(c, d)) < wmin(wmax(a, b), wmax(c, d));
        endfunction

        function sic_pkg::relation_t classify(pair_t p);
            wpoint_t a, b, c, d;
            int sc, sd, sa, sb;
            a.x = widen(p[0]); a.y = widen(p[1]);
            b.x = widen(p[2]); b.y = widen(p[3]);
            c.x = widen(p[4]); c.y = widen(p[5]);
            d.x = widen(p[6]); d.y = widen(p[7]);
            sc = orient_sign(a, b, c);
            sd = orient_sign(a, b, d);
            sa = orient_sign(c, d, a);
            sb = orient_sign(c, d, b);
            if (sc == 0 && sd == 0 && sa == 0 && sb == 0)
            begin
                if (spans_overlap(a.x, b.x, c.x, d.x) || spans_overlap(a.y, b.y, c.y, d.y))
                    return sic_pkg::REL_OVERLAP;
                if (on_segment(a, b, c) || on_segment(a, b, d)
                    || on_segment(c, d, a) || on_segment(c, d, b))
                    return sic_pkg::REL_TOUCH;
                return sic_pkg::REL_NONE;
            end
            if (sc * sd < 0 && sa * sb < 0)
                return sic_pkg::REL_PROPER;
            if ((sc == 0 && on_segment(a, b, c)) || (sd == 0 && on_segment(a, b, d))
                || (sa == 0 && on_segment(c, d, a)) || (sb == 0 && on_segment(c, d, b)))
                return sic_pkg::REL_TOUCH;
            return sic_pkg::REL_NONE;
        endfunction

        function void note_pair(pair_t p);
            expected_q = {expected_q, classify(p)};
        endfunction

        task report_mismatch(string msg);
            $display("mismatch: %s", msg);
            mismatches++;
        endtask

        task check_relation(logic [1:0] got);
            sic_pkg::relation_t exp_rel;
            if (expected_q.size() == 0)
            begin
                report_mismatch($sformatf("relation %0d with no pair outstanding", got));
            end
            else
            begin
                exp_rel = expected_q.pop_front();
                if (got !== exp_rel)
                    report_mismatch($sformatf("relation got %0d expected %0d (%s)",
                                              got, exp_rel, exp_rel.name()));
            end
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   pair_valid = 1'b0;
    logic   pair_stall;
    field_t ax = '0;
    field_t ay = '0;
    field_t bx = '0;
    field_t by = '0;
    field_t cx = '0;
    field_t cy = '0;
    field_t dx = '0;
    field_t dy = '0;
    logic   relation_valid;
    logic   relation_stall = 1'b0;
    logic [1:0] relation;

    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    logic burst_req = 1'b0;
    bit   burst_taken = 1'b0;
    int   burst_left = 0;
    int   cycle_count = 0;

    relation_scoreboard sb;

    segment_intersection_classifier dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .pair_valid     (pair_valid),
        .pair_stall     (pair_stall),
        .ax             (ax),
        .ay             (ay),
        .bx             (bx),
        .by             (by),
        .cx             (cx),
        .cy             (cy),
        .dx             (dx),
        .dy             (dy),
        .relation_valid (relation_valid),
        .relation_stall (relation_stall),
        .relation       (relation)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit)
        begin
            $display("FAIL segment_intersection_classifier");
            $finish;
        end
    end

    // hold off for one long stretch on request, else stall at random
    always @(posedge clk)
    begin
        if (burst_req && !burst_taken)
        begin
            burst_taken = 1'b1;
            burst_left = 400;
        end
        if (burst_left > 0)
        begin
            burst_left = burst_left - 1;
            relation_stall <= 1'b1;
        end
        else
        begin
            relation_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && relation_valid && !relation_stall)
            sb.check_relation(relation);
    end

    function automatic pair_t mk(field_t a0, field_t a1, field_t b0, field_t b1,
                                 field_t c0, field_t c1, field_t d0, field_t d1);
        pair_t p;
        p[0] = a0; p[1] = a1; p[2] = b0; p[3] = b1;
        p[4] = c0; p[5] = c1; p[6] = d0; p[7] = d1;
        return p;
    endfunction

    function automatic int rand_small(int r);
        return int'($urandom_range(0, 2 * r)) - r;
    endfunction

    function automatic field_t extreme_coord();
        case ($urandom_range(0, 5))
            0: return CoordMin;
            1: return CoordMax;
            2: return '0;
            3: return -1;
            4: return 1;
            default: return $urandom;
        endcase
    endfunction

    function automatic pair_t swap_points(pair_t p, int i, int j);
        pair_t q;
        q = p;
        q[2*i] = p[2*j]; q[2*i+1] = p[2*j+1];
        q[2*j] = p[2*i]; q[2*j+1] = p[2*i+1];
        return q;
    endfunction

    function automatic pair_t random_pair();
        pair_t p;
        int kind, ux, uy, scale, x0, y0, k, j, m;
        kind = $urandom_range(0, 99);
        if (kind < 15)
        begin
            foreach (p[i]) p[i] = $urandom;
        end
        else if (kind < 30)
        begin
            foreach (p[i]) p[i] = rand_small(4);
        end
        else if (kind < 40)
        begin
            foreach (p[i]) p[i] = rand_small(1000);
        end
        else if (kind < 82)
        begin
            scale = 1 << $urandom_range(0, 14);
            ux = rand_small(3) * scale;
            uy = rand_small(3) * scale;
            x0 = rand_small(1 << 29);
            y0 = rand_small(1 << 29);
            if (kind < 55)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    k = rand_small(4);
                    p[2*i] = x0 + k * ux;
                    p[2*i+1] = y0 + k * uy;
                end
            end
            else
            begin
                k = $urandom_range(0, 4);
                p[0] = x0;          p[1] = y0;
                p[2] = x0 + 4 * ux; p[3] = y0 + 4 * uy;
                p[4] = x0 + k * ux; p[5] = y0 + k * uy;
                p[6] = x0 + rand_small(60) * scale;
                p[7] = y0 + rand_small(60) * scale;
                if (kind >= 75)
                begin
                    if ($urandom_range(0, 1))
                        p[4] = p[4] + 1;
                    else
                        p[5] = p[5] - 1;
                end
            end
        end
        else if (kind < 92)
        begin
            foreach (p[i]) p[i] = extreme_coord();
        end
        else
        begin
            foreach (p[i]) p[i] = rand_small(20);
            j = $urandom_range(0, 3);
            m = $urandom_range(0, 3);
            p[2*j] = p[2*m];
            p[2*j+1] = p[2*m+1];
        end
        if ($urandom_range(0, 1))
            p = swap_points(p, 0, 1);
        if ($urandom_range(0, 1))
            p = swap_points(p, 2, 3);
        if ($urandom_range(0, 1))
        begin
            p = swap_points(p, 0, 2);
            p = swap_points(p, 1, 3);
        end
        return p;
    endfunction

    task automatic send_pair(pair_t p);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            pair_valid <= 1'b0;
            @(posedge clk);
        end
        pair_valid <= 1'b1;
        ax <= p[0]; ay <= p[1]; bx <= p[2]; by <= p[3];
        cx <= p[4]; cy <= p[5]; dx <= p[6]; dy <= p[7];
        do
            @(posedge clk);
        while (pair_stall);
        sb.note_pair(p);
    endtask

    task automatic send_random(int count);
        repeat (count) send_pair(random_pair());
    endtask

    // drop valid and hold until every relation word is back
    task automatic wait_drained();
        pair_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic send_directed();
        send_pair(mk(0, 0, 4, 4, 0, 4, 4, 0));
        send_pair(mk(0, 0, 4, 0, 2, 0, 2, 3));
        send_pair(mk(2, 0, 2, 5, 0, 0, 4, 0));
        send_pair(mk(0, 0, 2, 2, 2, 2, 4, 0));
        send_pair(mk(0, 0, 1, 1, 3, 0, 4, -2));
        send_pair(mk(0, 0, 4, 0, 0, 1, 4, 1));
        send_pair(mk(0, 0, 4, 0, 2, 0, 6, 0));
        send_pair(mk(0, 0, 4, 0, 4, 0, 8, 0));
        send_pair(mk(0, 0, 2, 0, 3, 0, 5, 0));
        send_pair(mk(0, 0, 0, 5, 0, 3, 0, -2));
        send_pair(mk(0, 0, 6, 6, 2, 2, 3, 3));
        send_pair(mk(0, 0, 4, 4, 2, 2, 2, 2));
        send_pair(mk(0, 0, 4, 4, 2, 3, 2, 3));
        send_pair(mk(1, 1, 1, 1, 1, 1, 1, 1));
        send_pair(mk(1, 1, 1, 1, 2, 2, 2, 2));
        send_pair(mk(0, 0, 3, 7, 3, 7, 0, 0));
        send_pair(mk(CoordMin, CoordMin, CoordMax, CoordMax,
                     CoordMin, CoordMax, CoordMax, CoordMin));
        send_pair(mk(CoordMin, CoordMin, CoordMax, CoordMax, 0, 0, -1, -1));
        send_pair(mk(CoordMin, CoordMin, CoordMax, CoordMin, 0, CoordMin, 0, CoordMax));
        send_pair(mk(CoordMax, CoordMax, CoordMax, CoordMax,
                     CoordMax, CoordMax, CoordMax, CoordMax));
        send_pair(mk(CoordMin, CoordMin, CoordMin, CoordMin,
                     CoordMin, CoordMin, CoordMin, CoordMin));
        send_pair(mk(CoordMin, CoordMin, CoordMax, CoordMax, 0, 1, 1, 2));
        send_pair(mk(CoordMin, CoordMax, CoordMax, CoordMin, -1, 0, 0, -1));
    endtask

    initial
    begin
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 36;
        recv_idle_pct <= 49;
        send_directed();
        send_random(RandomPerPhase);
        wait_drained();

        send_idle_pct = 49;
        recv_idle_pct <= 36;
        send_random(RandomPerPhase);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct <= 0;
        burst_req <= 1'b1;
        send_random(RandomPerPhase);
        wait_drained();

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("PASS segment_intersection_classifier");
        else
            $display("FAIL segment_intersection_classifier");
        $finish;
    end

endmodule
